FILE: rtl/dst_pkg.sv
// shared constants and types of the descriptor slot table
`timescale 1ns / 1ps
`default_nettype none

package dst_pkg;

    // default sizes
    localparam int SLOTS_DEF       = 64;
    localparam int HANDLE_BITS_DEF = 32;

    // field widths fixed by the request and response formats
    localparam int MODE_W     = 2;
    localparam int REQ_W      = 8;
    localparam int REQ_MAG_W  = 7;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 6;

    // free search works on groups of slots
    localparam int GRP   = 16;
    localparam int GRP_W = 4;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GET   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADF   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXISTS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // valid-bit update toward the free map
    typedef struct packed {
        logic wr_en;
        logic set;
    } map_upd_t;

endpackage

`default_nettype wire

FILE: rtl/dst_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface dst_req_if #(
    parameter int HANDLE_BITS = dst_pkg::HANDLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [dst_pkg::MODE_W-1:0]    mode;
    logic signed [dst_pkg::REQ_W-1:0] slot_request;
    logic [HANDLE_BITS-1:0]        handle_in;

    modport source (output valid, output mode, output slot_request, output handle_in,
                    input ready);
    modport sink   (input valid, input mode, input slot_request, input handle_in,
                    output ready);
endinterface

interface dst_rsp_if #(
    parameter int HANDLE_BITS = dst_pkg::HANDLE_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic [dst_pkg::STATUS_W-1:0]    status;
    logic [dst_pkg::SLOT_OUT_W-1:0]  slot_out;
    logic [HANDLE_BITS-1:0]          handle_out;

    modport source (output valid, output status, output slot_out, output handle_out,
                    input ready);
    modport sink   (input valid, input status, input slot_out, input handle_out,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/descriptor_slot_table.sv
// descriptor slot table top level: sequencer, handle memory and free map
//
// Each request is one table operation (allocate at a given slot, allocate at
// the lowest free slot, free, get handle) and gives exactly one response.
// In the cycle a request is accepted the handle memory is read at the
// requested slot and the free map picks the first group of sixteen slots
// that still has room; in the execute state, once the output register is
// empty or draining, the bit inside that group is found, the valid bit and
// handle are written back and the response is loaded into the output
// register. No new request is taken until the last one leaves the execute
// state; the response register lets the next request in while the last
// response waits. The pace is set by the registered read data of the handle
// memory and the two-level free search. Valid bits are flip-flops cleared by
// reset, so no clearing pass is needed; unwritten handles are never returned.
`timescale 1ns / 1ps
`default_nettype none

module descriptor_slot_table #(
    parameter int SLOTS       = dst_pkg::SLOTS_DEF,
    parameter int HANDLE_BITS = dst_pkg::HANDLE_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dst_req_if.sink    req,
    dst_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(SLOTS);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;

    // captured request
    logic [dst_pkg::MODE_W-1:0]     mode_reg;
    logic [dst_pkg::REQ_W-1:0]      slot_req_reg;
    logic [HANDLE_BITS-1:0]         handle_reg;

    // response register
    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;
    logic [dst_pkg::STATUS_W-1:0]   status_reg;
    logic [dst_pkg::STATUS_W-1:0]   status_next;
    logic [dst_pkg::SLOT_OUT_W-1:0] slot_reg;
    logic [dst_pkg::SLOT_OUT_W-1:0] slot_next;
    logic [HANDLE_BITS-1:0]         hout_reg;
    logic [HANDLE_BITS-1:0]         hout_next;

    logic                           accept;
    logic                           live_in_range;
    logic [IDX_W-1:0]               live_idx;
    logic                           in_range;
    logic [IDX_W-1:0]               req_idx;
    logic                           occupied;
    logic                           finish;

    // memory and map hookup
    logic                           look_valid;
    logic                           free_found;
    logic [IDX_W-1:0]               free_idx;
    dst_pkg::map_upd_t              upd;
    logic [IDX_W-1:0]               wr_idx;
    logic [HANDLE_BITS-1:0]         rdata;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    // range check on the live request, used for the early memory read
    assign live_in_range = !req.slot_request[dst_pkg::REQ_W-1]
                        && (int'(req.slot_request[dst_pkg::REQ_MAG_W-1:0]) < SLOTS);
    assign live_idx      = IDX_W'(req.slot_request[dst_pkg::REQ_MAG_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= req.mode;
            slot_req_reg <= req.slot_request;
            handle_reg   <= req.handle_in;
        end
    end

    // range check on the captured request
    assign in_range = !slot_req_reg[dst_pkg::REQ_W-1]
                   && (int'(slot_req_reg[dst_pkg::REQ_MAG_W-1:0]) < SLOTS);
    assign req_idx  = IDX_W'(slot_req_reg[dst_pkg::REQ_MAG_W-1:0]);
    assign occupied = in_range && look_valid;

    // response can be loaded when the register is empty or draining
    assign finish = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        slot_next      = slot_reg;
        hout_next      = hout_reg;
        upd            = '0;
        wr_idx         = req_idx;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (finish)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    status_next    = dst_pkg::ST_BADF;
                    slot_next      = '0;
                    hout_next      = '0;
                    case (mode_reg)
                        dst_pkg::MODE_ALLOC:
                        begin
                            if (slot_req_reg[dst_pkg::REQ_W-1])
                            begin
                                // lowest free slot
                                if (free_found)
                                begin
                                    status_next = dst_pkg::ST_OK;
                                    slot_next   = dst_pkg::SLOT_OUT_W'(free_idx);
                                    wr_idx      = free_idx;
                                    upd.wr_en   = 1'b1;
                                    upd.set     = 1'b1;
                                end
                                else
                                begin
                                    status_next = dst_pkg::ST_FULL;
                                end
                            end
                            else if (!in_range)
                            begin
                                status_next = dst_pkg::ST_BADF;
                            end
                            else if (occupied)
                            begin
                                status_next = dst_pkg::ST_EXISTS;
                            end
                            else
                            begin
                                status_next = dst_pkg::ST_OK;
                                slot_next   = dst_pkg::SLOT_OUT_W'(req_idx);
                                upd.wr_en   = 1'b1;
                                upd.set     = 1'b1;
                            end
                        end
                        dst_pkg::MODE_FREE:
                        begin
                            if (occupied)
                            begin
                                status_next = dst_pkg::ST_OK;
                                slot_next   = dst_pkg::SLOT_OUT_W'(req_idx);
                                upd.wr_en   = 1'b1;
                                upd.set     = 1'b0;
                            end
                        end
                        dst_pkg::MODE_GET:
                        begin
                            if (occupied)
                            begin
                                status_next = dst_pkg::ST_OK;
                                slot_next   = dst_pkg::SLOT_OUT_W'(req_idx);
                                hout_next   = rdata;
                            end
                        end
                        default:
                        begin
                            status_next = dst_pkg::ST_BADF;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            status_reg    <= '0;
            slot_reg      <= '0;
            hout_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            status_reg    <= status_next;
            slot_reg      <= slot_next;
            hout_reg      <= hout_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.slot_out   = slot_reg;
    assign rsp.handle_out = hout_reg;

    dst_handle_ram #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (upd.wr_en && upd.set),
        .waddr (wr_idx),
        .wdata (handle_reg),
        .re    (accept && live_in_range),
        .raddr (live_idx),
        .rdata (rdata)
    );

    dst_free_map #(
        .SLOTS (SLOTS)
    ) u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .capture    (accept),
        .look_idx   (req_idx),
        .look_valid (look_valid),
        .upd        (upd),
        .upd_idx    (wr_idx),
        .free_found (free_found),
        .free_idx   (free_idx)
    );

endmodule

`default_nettype wire

FILE: rtl/dst_handle_ram.sv
// handle memory: one write port, one read port with registered data
`timescale 1ns / 1ps
`default_nettype none

module dst_handle_ram #(
    parameter int SLOTS       = dst_pkg::SLOTS_DEF,
    parameter int HANDLE_BITS = dst_pkg::HANDLE_BITS_DEF,
    localparam int IDX_W      = $clog2(SLOTS)
) (
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [IDX_W-1:0]       waddr,
    input  wire logic [HANDLE_BITS-1:0] wdata,
    input  wire logic                   re,
    input  wire logic [IDX_W-1:0]       raddr,
    output logic      [HANDLE_BITS-1:0] rdata
);

    logic [HANDLE_BITS-1:0] mem [SLOTS];
    logic [HANDLE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/dst_free_map.sv
// slot valid bits and the two-level lowest-free search
`timescale 1ns / 1ps
`default_nettype none

module dst_free_map #(
    parameter int SLOTS  = dst_pkg::SLOTS_DEF,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              capture,
    input  wire logic [IDX_W-1:0]  look_idx,
    output logic                   look_valid,
    input  wire dst_pkg::map_upd_t upd,
    input  wire logic [IDX_W-1:0]  upd_idx,
    output logic                   free_found,
    output logic      [IDX_W-1:0]  free_idx
);

    localparam int GROUPS = (SLOTS + dst_pkg::GRP - 1) / dst_pkg::GRP;
    localparam int PAD    = GROUPS * dst_pkg::GRP;
    localparam int GI_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    logic [SLOTS-1:0]        valid_reg;
    logic [PAD-1:0]          padded;
    logic                    grp_hit;
    logic [GI_W-1:0]         grp_sel;
    logic                    hit_reg;
    logic [GI_W-1:0]         grp_reg;
    logic [dst_pkg::GRP-1:0] grp_bits;
    logic [dst_pkg::GRP_W-1:0] off;

    // slots past the end look occupied
    always_comb
    begin
        padded             = '1;
        padded[SLOTS-1:0]  = valid_reg;
    end

    // first group with a free slot
    always_comb
    begin
        grp_hit = 1'b0;
        grp_sel = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (!(&padded[g*dst_pkg::GRP +: dst_pkg::GRP]))
            begin
                grp_hit = 1'b1;
                grp_sel = GI_W'(g);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            hit_reg <= grp_hit;
            grp_reg <= grp_sel;
        end
    end

    // first free slot inside the chosen group
    assign grp_bits = padded[{grp_reg, dst_pkg::GRP_W'(0)} +: dst_pkg::GRP];

    always_comb
    begin
        off = '0;
        for (int b = dst_pkg::GRP - 1; b >= 0; b--)
        begin
            if (!grp_bits[b])
            begin
                off = dst_pkg::GRP_W'(b);
            end
        end
    end

    assign free_found = hit_reg;
    assign free_idx   = IDX_W'({grp_reg, off});
    assign look_valid = valid_reg[look_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (upd.wr_en)
        begin
            valid_reg[upd_idx] <= upd.set;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dst_checker.sv
// port-level checker of the descriptor slot table and its bind
`timescale 1ns / 1ps
`default_nettype none

module dst_checker #(
    parameter int HANDLE_BITS = dst_pkg::HANDLE_BITS_DEF
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           req_valid,
    input wire logic                           req_ready,
    input wire logic                           rsp_valid,
    input wire logic                           rsp_ready,
    input wire logic [dst_pkg::STATUS_W-1:0]   rsp_status,
    input wire logic [dst_pkg::SLOT_OUT_W-1:0] rsp_slot_out,
    input wire logic [HANDLE_BITS-1:0]         rsp_handle_out
);

    // a response that is not taken stays up
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // one request in flight: no request right after an accepted one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

    // a new response only comes out of the execute cycle
    a_rsp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("response without a request in work");

    // failed operations carry no slot and no handle
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != dst_pkg::ST_OK) |->
            (rsp_slot_out == '0) && (rsp_handle_out == '0))
        else $error("failed operation returned data");

endmodule

bind descriptor_slot_table dst_checker #(
    .HANDLE_BITS (HANDLE_BITS)
) u_dst_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_slot_out   (rsp.slot_out),
    .rsp_handle_out (rsp.handle_out)
);

`default_nettype wire

FILE: bench/dst_table_checker.sv
// response checker for the descriptor slot table: slot state predictor and response compare
`timescale 1ns / 1ps

module dst_table_checker
    import dst_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dst_req_if        req,
    dst_rsp_if        rsp,
    output int        fail_count,
    output int        pending,
    output int        status_hits [4]
);

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [HANDLE_BITS-1:0] handle;
    } table_rsp_t;

    // shadow copy of the slot table
    bit                     slot_busy [SLOTS];
    logic [HANDLE_BITS-1:0] slot_held [SLOTS];

    table_rsp_t due_rsp [$];

    function automatic table_rsp_t apply_table_op(input logic [MODE_W-1:0] mode,
                                                  input logic signed [REQ_W-1:0] slot_req,
                                                  input logic [HANDLE_BITS-1:0] hin);
        table_rsp_t r;
        int idx;
        bit found;
        r = '{status: ST_BADF, slot: '0, handle: '0};
        idx = slot_req;
        found = 1'b0;
        if (mode == MODE_ALLOC)
        begin
            if (idx >= SLOTS)
            begin
                r.status = ST_BADF;
            end
            else if (idx >= 0)
            begin
                if (slot_busy[idx])
                begin
                    r.status = ST_EXISTS;
                end
                else
                begin
                    slot_busy[idx] = 1'b1;
                    slot_held[idx] = hin;
                    r.status = ST_OK;
                    r.slot = idx[SLOT_OUT_W-1:0];
                end
            end
            else
            begin
                // lowest free slot, or full
                r.status = ST_FULL;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && !slot_busy[i])
                    begin
                        found = 1'b1;
                        slot_busy[i] = 1'b1;
                        slot_held[i] = hin;
                        r.status = ST_OK;
                        r.slot = i[SLOT_OUT_W-1:0];
                    end
                end
            end
        end
        else if (mode == MODE_FREE || mode == MODE_GET)
        begin
            if (idx >= 0 && idx < SLOTS && slot_busy[idx])
            begin
                r.status = ST_OK;
                r.slot = idx[SLOT_OUT_W-1:0];
                if (mode == MODE_FREE)
                    slot_busy[idx] = 1'b0;
                else
                    r.handle = slot_held[idx];
            end
        end
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        pending = 0;
        for (int i = 0; i < 4; i++)
            status_hits[i] = 0;
        for (int i = 0; i < SLOTS; i++)
            slot_busy[i] = 1'b0;
    end

    always @(posedge clk)
    begin
        table_rsp_t want;
        if (rst_n)
        begin
            // compare before pushing so a stray response is not matched to a new request
            if (rsp.valid && rsp.ready)
            begin
                if (due_rsp.size() == 0)
                begin
                    $error("response with no request outstanding: status %0d slot %0d handle %h",
                           rsp.status, rsp.slot_out, rsp.handle_out);
                    fail_count++;
                end
                else
                begin
                    want = due_rsp.pop_front();
                    status_hits[rsp.status]++;
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.slot_out !== want.slot)
                    begin
                        $error("slot_out: expected %0d, got %0d", want.slot, rsp.slot_out);
                        fail_count++;
                    end
                    if (rsp.handle_out !== want.handle)
                    begin
                        $error("handle_out: expected %h, got %h", want.handle, rsp.handle_out);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                due_rsp.push_back(apply_table_op(req.mode, req.slot_request, req.handle_in));
            pending <= due_rsp.size();
        end
    end

endmodule

FILE: bench/descriptor_slot_table_tb.sv
// testbench top for the descriptor slot table: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module descriptor_slot_table_tb;
    import dst_pkg::*;

    localparam int SLOTS       = 64;
    localparam int HANDLE_BITS = 32;

    // the fourth opcode is unused by the block and must come back as bad descriptor
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    // longest receiver hold-off and the watchdog limit on cycles with no handshake
    localparam int STALL_BURST_CYCLES = 200;
    localparam int WATCHDOG_LIMIT     = 2000;

    // per-phase sizing of the random part
    localparam int FILL_OPS  = SLOTS + 4;
    localparam int MIXED_OPS = 300;
    localparam int SQUEEZE_OPS = 40;

    logic clk;
    logic rst_n;

    dst_req_if #(.HANDLE_BITS(HANDLE_BITS)) req_ch ();
    dst_rsp_if #(.HANDLE_BITS(HANDLE_BITS)) rsp_ch ();

    int fail_count;
    int pending;
    int status_hits [4];

    int src_idle_pct;
    int rcv_stall_pct;
    bit stall_burst;
    int n_sent;
    int idle_cycles;

    descriptor_slot_table #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    dst_table_checker #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .pending     (pending),
        .status_hits (status_hits)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog: any run of cycles with no handshake on either side is bounded
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("descriptor_slot_table_tb: errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // response side: random back-pressure, plus a long hold-off when the stimulus asks
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_burst)
            begin
                stall_burst = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (STALL_BURST_CYCLES - 1)
                begin
                    @(negedge clk);
                    rsp_ch.ready <= 1'b0;
                end
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    // present one request, with random idle cycles ahead of it, and hold it until taken
    task automatic send_op(input logic [MODE_W-1:0] m, input logic signed [REQ_W-1:0] s,
                           input logic [HANDLE_BITS-1:0] h);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= m;
        req_ch.slot_request <= s;
        req_ch.handle_in    <= h;
        do
            @(posedge clk);
        while (!req_ch.ready);
        n_sent++;
    endtask

    function automatic logic [HANDLE_BITS-1:0] pick_handle();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return '0;
        else if (pick < 10)
            return '1;
        return HANDLE_BITS'($urandom);
    endfunction

    // mixed traffic: slots mostly in range with a hot low window, some out of range
    // and some negative; allocate leans toward lowest-free requests
    task automatic send_mixed_op();
        logic [MODE_W-1:0] m;
        logic signed [REQ_W-1:0] s;
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            m = MODE_ALLOC;
        else if (pick < 65)
            m = MODE_FREE;
        else if (pick < 95)
            m = MODE_GET;
        else
            m = MODE_NONE;
        pick = $urandom_range(99);
        if (pick < 55)
            s = REQ_W'($urandom_range(SLOTS - 1));
        else if (pick < 75)
            s = REQ_W'($urandom_range(7));
        else if (pick < 87)
            s = REQ_W'($urandom_range(127, SLOTS));
        else
            s = REQ_W'($urandom_range(255, 128));
        if (m == MODE_ALLOC && $urandom_range(2) == 0)
            s = REQ_W'($urandom_range(255, 128));
        send_op(m, s, pick_handle());
    endtask

    // lowest-free allocations until the table runs full, and a few past that
    task automatic fill_table();
        for (int k = 0; k < FILL_OPS; k++)
            send_op(MODE_ALLOC, REQ_W'($urandom_range(255, 128)), pick_handle());
    endtask

    // free every slot once, in a scrambled order; an odd stride keeps it a permutation
    task automatic drain_table();
        int ofs;
        ofs = $urandom_range(SLOTS - 1);
        for (int k = 0; k < SLOTS; k++)
            send_op(MODE_FREE, REQ_W'((k * 37 + ofs) % SLOTS), pick_handle());
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = MODE_ALLOC;
        req_ch.slot_request = '0;
        req_ch.handle_in    = '0;
        src_idle_pct        = 0;
        rcv_stall_pct       = 0;
        stall_burst         = 1'b0;
        n_sent              = 0;
        idle_cycles         = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, range edges, exists, zero and all-ones handles,
        // negative slots, unused opcode, free then reuse of the lowest slot
        send_op(MODE_GET,   8'sd0,   32'h0);
        send_op(MODE_FREE,  8'sd0,   32'h0);
        send_op(MODE_ALLOC, 8'sd64,  32'h1234_5678);
        send_op(MODE_ALLOC, 8'sd127, 32'h8765_4321);
        send_op(MODE_ALLOC, 8'sd63,  32'h0000_0000);
        send_op(MODE_ALLOC, 8'sd63,  32'hFFFF_FFFF);
        send_op(MODE_GET,   8'sd63,  32'hFFFF_FFFF);
        send_op(MODE_ALLOC, 8'shFF,  32'hFFFF_FFFF);
        send_op(MODE_ALLOC, 8'sh80,  32'hA5A5_A5A5);
        send_op(MODE_GET,   8'sd0,   32'h0);
        send_op(MODE_GET,   8'shFF,  32'h0);
        send_op(MODE_FREE,  8'sh80,  32'h0);
        send_op(MODE_GET,   8'sd64,  32'h0);
        send_op(MODE_FREE,  8'sd127, 32'h0);
        send_op(MODE_NONE,  8'sd0,   32'hDEAD_BEEF);
        send_op(MODE_NONE,  8'shFF,  32'hFFFF_FFFF);
        send_op(MODE_FREE,  8'sd0,   32'h0);
        send_op(MODE_FREE,  8'sd0,   32'h0);
        send_op(MODE_GET,   8'sd0,   32'h0);
        send_op(MODE_ALLOC, 8'shFF,  32'h5A5A_5A5A);
        send_op(MODE_GET,   8'sd1,   32'h0);
        send_op(MODE_GET,   8'sd0,   32'h0);
        send_op(MODE_FREE,  8'sd63,  32'h0);
        send_op(MODE_ALLOC, 8'sd63,  32'h0000_0001);

        // random phases: no idling, sender gaps, receiver stalls, both
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct = 0;
                    rcv_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 57;
                    rcv_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    rcv_stall_pct = 57;
                end
                default:
                begin
                    src_idle_pct = 16;
                    rcv_stall_pct = 16;
                end
            endcase
            fill_table();
            for (int k = 0; k < MIXED_OPS / 2; k++)
                send_mixed_op();
            drain_table();
            for (int k = 0; k < MIXED_OPS / 2; k++)
                send_mixed_op();

            if (ph == 0)
            begin
                // receiver holds off for a long stretch while requests keep coming,
                // so the response register fills and the request side backs up
                stall_burst = 1'b1;
                for (int k = 0; k < SQUEEZE_OPS; k++)
                    send_mixed_op();
                // then the sender goes quiet until every response is back
                @(negedge clk);
                req_ch.valid <= 1'b0;
                wait_drained();
            end
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);

        $display("descriptor_slot_table_tb: %0d requests over four idling phases with fill, drain",
                 n_sent);
        $display("  and mixed traffic; responses ok %0d, bad descriptor %0d, exists %0d, full %0d",
                 status_hits[ST_OK], status_hits[ST_BADF], status_hits[ST_EXISTS],
                 status_hits[ST_FULL]);
        if (fail_count == 0)
            $display("descriptor_slot_table_tb: clean");
        else
            $display("descriptor_slot_table_tb: errors");
        $finish;
    end

endmodule
